// File: rtl/core/esc_pkg.sv
`default_nettype none

package esc_pkg;

    localparam int unsigned EpochW = 32;
    localparam int unsigned TzW    = 11;
    localparam int unsigned DaysW  = 15;
    localparam int unsigned SodW   = 17;
    localparam int unsigned YdayW  = 9;

    localparam logic [SodW-1:0]   SECS_PER_DAY = 17'd86400;
    localparam logic [SodW-1:0]   SECS_PER_MIN = 17'd60;
    localparam logic [SodW-1:0]   DAYS_PER_WK  = 17'd7;
    localparam logic [EpochW-1:0] MAX_LOCAL    = 32'd2208988799;
    localparam logic [10:0]       FIRST_YEAR   = 11'd1970;
    localparam logic [6:0]        LAST_YEAR_OFF = 7'd69;  // 2039 - 1970
    localparam logic [DaysW-1:0]  WK_SHIFT     = 15'd3;   // epoch day was a Thursday

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOCAL,
        S_DAY,
        S_MIN,
        S_HOUR,
        S_WEEK,
        S_DATE,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        W_IDLE,
        W_YEAR,
        W_MONTH
    } t_walk_phase;

    typedef struct packed {
        logic              start;
        logic [EpochW-1:0] num;
        logic [SodW-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [EpochW-1:0] quo;
        logic [SodW-1:0]   rem;
    } t_div_rsp;

    typedef struct packed {
        logic        done;
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } t_walk_rsp;

    typedef struct packed {
        logic [10:0]      year;
        logic [3:0]       month;
        logic [4:0]       day_of_month;
        logic [2:0]       weekday;
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [5:0]       second;
        logic [DaysW-1:0] day_count;
        logic [SodW-1:0]  seconds_of_day;
        logic             clamped;
    } t_result;

    // 1970..2039: every fourth year is leap, 2000 included
    function automatic logic is_leap(input logic [6:0] off);
        logic [10:0] y;
        y = FIRST_YEAR + {4'd0, off};
        return (y[1:0] == 2'd0);
    endfunction

    function automatic logic [YdayW-1:0] month_start(input logic leap, input logic [3:0] m);
        logic [YdayW-1:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && (m >= 4'd2)) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/esc_in_if.sv
`default_nettype none

interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

// File: rtl/core/esc_out_if.sv
`default_nettype none

interface esc_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [14:0] day_count;
    logic [16:0] seconds_of_day;
    logic        clamped;

    modport source (
        output valid, output year, output month, output day_of_month, output weekday,
        output hour, output minute, output second, output day_count,
        output seconds_of_day, output clamped, input ready
    );
    modport sink (
        input valid, input year, input month, input day_of_month, input weekday,
        input hour, input minute, input second, input day_count,
        input seconds_of_day, input clamped, output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/esc_serdiv.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module esc_serdiv (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire esc_pkg::t_div_req i_req,
    output esc_pkg::t_div_rsp      o_rsp
);
    import esc_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [4:0]        r_cnt, n_cnt;
    logic [SodW-1:0]   r_rem, n_rem;
    logic [EpochW-1:0] r_quo, n_quo;
    logic [SodW-1:0]   r_den, n_den;

    logic [SodW:0] trial;
    logic [SodW:0] diff;
    logic          ge;

    always_comb begin
        trial  = {r_rem, r_quo[EpochW-1]};
        ge     = (trial >= {1'b0, r_den});
        diff   = trial - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = ge ? diff[SodW-1:0] : trial[SodW-1:0];
            n_quo = {r_quo[EpochW-2:0], ge};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// File: rtl/core/esc_datewalk.sv
`default_nettype none

// Steps through year starts one year a cycle, then month starts downwards.
module esc_datewalk (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [esc_pkg::DaysW-1:0]  i_days,
    output esc_pkg::t_walk_rsp         o_rsp
);
    import esc_pkg::*;

    t_walk_phase      r_phase, n_phase;
    logic [DaysW-1:0] r_days, n_days;
    logic [DaysW-1:0] r_start, n_start;
    logic [6:0]       r_off, n_off;
    logic [YdayW-1:0] r_yday, n_yday;
    logic [3:0]       r_m, n_m;
    logic             r_leap, n_leap;
    t_walk_rsp        r_rsp, n_rsp;

    logic             leap_now;
    logic [DaysW:0]   year_end;
    logic [YdayW-1:0] ms;

    always_comb begin
        leap_now = is_leap(r_off);
        year_end = {1'b0, r_start} + (leap_now ? 16'd366 : 16'd365);
        ms       = month_start(r_leap, r_m);
        n_phase  = r_phase;
        n_days   = r_days;
        n_start  = r_start;
        n_off    = r_off;
        n_yday   = r_yday;
        n_m      = r_m;
        n_leap   = r_leap;
        n_rsp    = r_rsp;
        n_rsp.done = 1'b0;
        case (r_phase)
            W_IDLE: begin
                if (i_start) begin
                    n_phase = W_YEAR;
                    n_days  = i_days;
                    n_start = '0;
                    n_off   = '0;
                end
            end
            W_YEAR: begin
                if ((r_off >= LAST_YEAR_OFF) || ({1'b0, r_days} < year_end)) begin
                    n_yday  = YdayW'(r_days - r_start);
                    n_leap  = leap_now;
                    n_m     = 4'd11;
                    n_phase = W_MONTH;
                end else begin
                    n_start = year_end[DaysW-1:0];
                    n_off   = r_off + 7'd1;
                end
            end
            W_MONTH: begin
                if ((r_m != 4'd0) && (ms > r_yday)) begin
                    n_m = r_m - 4'd1;
                end else begin
                    n_rsp.done         = 1'b1;
                    n_rsp.year         = FIRST_YEAR + {4'd0, r_off};
                    n_rsp.month        = r_m + 4'd1;
                    n_rsp.day_of_month = 5'(r_yday - ms + 9'd1);
                    n_phase            = W_IDLE;
                end
            end
            default: n_phase = W_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= W_IDLE;
            r_rsp.done <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_rsp.done <= n_rsp.done;
        end
        r_days              <= n_days;
        r_start             <= n_start;
        r_off               <= n_off;
        r_yday              <= n_yday;
        r_m                 <= n_m;
        r_leap              <= n_leap;
        r_rsp.year          <= n_rsp.year;
        r_rsp.month         <= n_rsp.month;
        r_rsp.day_of_month  <= n_rsp.day_of_month;
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// File: rtl/core/epoch_seconds_to_calendar.sv
`default_nettype none

// Steps: the zone shift and clamp, four 32-bit divider passes, the year/month walk
//   (one year a cycle, then one month a cycle), then the load of the output.
// Items are worked on one at a time, through the shared bit-serial divider and the
//   year/month walk.
// A new item is taken while a result waits.
// Reset: synchronous, active low; clears the sequencer, result valid and zone offset.
module epoch_seconds_to_calendar (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [10:0] i_cfg_data,
    esc_in_if.sink     i_in,
    esc_out_if.source  o_out
);
    import esc_pkg::*;

    // Sequencer and working registers
    t_state             r_state, n_state;
    logic signed [TzW-1:0] r_tz;
    logic [EpochW-1:0]  r_epoch, n_epoch;
    logic [DaysW-1:0]   r_days, n_days;
    logic [SodW-1:0]    r_sod, n_sod;
    logic [5:0]         r_second, n_second;
    logic [5:0]         r_minute, n_minute;
    logic [4:0]         r_hour, n_hour;
    logic [2:0]         r_weekday, n_weekday;
    logic [10:0]        r_year, n_year;
    logic [3:0]         r_month, n_month;
    logic [4:0]         r_mday, n_mday;
    logic               r_clamped, n_clamped;

    // Output stage: holds a finished result while the next item is worked on
    logic               r_out_valid, n_out_valid;
    t_result            r_res, n_res;

    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic               walk_start;
    t_walk_rsp          walk_rsp;

    // Local seconds: UTC minus 60 * minutes west, 34-bit signed span
    logic signed [33:0] tz_ext;
    logic signed [33:0] local_s;
    logic [EpochW-1:0]  local_t;
    logic               local_clamp;

    esc_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    esc_datewalk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (walk_start),
        .i_days  (r_days),
        .o_rsp   (walk_rsp)
    );

    always_comb begin
        tz_ext  = 34'(r_tz);
        local_s = $signed({2'b00, r_epoch}) - ((tz_ext <<< 6) - (tz_ext <<< 2));
        if (local_s[33]) begin
            local_t     = '0;
            local_clamp = 1'b1;
        end else if (local_s > $signed({2'b00, MAX_LOCAL})) begin
            local_t     = MAX_LOCAL;
            local_clamp = 1'b1;
        end else begin
            local_t     = local_s[EpochW-1:0];
            local_clamp = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_days      = r_days;
        n_sod       = r_sod;
        n_second    = r_second;
        n_minute    = r_minute;
        n_hour      = r_hour;
        n_weekday   = r_weekday;
        n_year      = r_year;
        n_month     = r_month;
        n_mday      = r_mday;
        n_clamped   = r_clamped;
        n_out_valid = r_out_valid;
        n_res       = r_res;
        div_req     = '0;
        walk_start  = 1'b0;

        // result leaves on its transfer
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_epoch = i_in.epoch_seconds;
                    n_state = S_LOCAL;
                end
            end
            S_LOCAL: begin
                // clamp and launch days / seconds-of-day split
                n_clamped     = local_clamp;
                div_req.start = 1'b1;
                div_req.num   = local_t;
                div_req.den   = SECS_PER_DAY;
                n_state       = S_DAY;
            end
            S_DAY: begin
                if (div_rsp.done) begin
                    n_days        = div_rsp.quo[DaysW-1:0];
                    n_sod         = div_rsp.rem;
                    div_req.start = 1'b1;
                    div_req.num   = EpochW'(div_rsp.rem);
                    div_req.den   = SECS_PER_MIN;
                    n_state       = S_MIN;
                end
            end
            S_MIN: begin
                if (div_rsp.done) begin
                    n_second      = div_rsp.rem[5:0];
                    div_req.start = 1'b1;
                    div_req.num   = EpochW'(div_rsp.quo[10:0]);
                    div_req.den   = SECS_PER_MIN;
                    n_state       = S_HOUR;
                end
            end
            S_HOUR: begin
                if (div_rsp.done) begin
                    n_hour        = div_rsp.quo[4:0];
                    n_minute      = div_rsp.rem[5:0];
                    div_req.start = 1'b1;
                    div_req.num   = EpochW'(r_days + WK_SHIFT);
                    div_req.den   = DAYS_PER_WK;
                    n_state       = S_WEEK;
                end
            end
            S_WEEK: begin
                if (div_rsp.done) begin
                    n_weekday  = div_rsp.rem[2:0] + 3'd1;
                    walk_start = 1'b1;
                    n_state    = S_DATE;
                end
            end
            S_DATE: begin
                // date kept aside: the output stage may still hold the last result
                if (walk_rsp.done) begin
                    n_year  = walk_rsp.year;
                    n_month = walk_rsp.month;
                    n_mday  = walk_rsp.day_of_month;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output stage to free up
                if (!n_out_valid) begin
                    n_res.year           = r_year;
                    n_res.month          = r_month;
                    n_res.day_of_month   = r_mday;
                    n_res.weekday        = r_weekday;
                    n_res.hour           = r_hour;
                    n_res.minute         = r_minute;
                    n_res.second         = r_second;
                    n_res.day_count      = r_days;
                    n_res.seconds_of_day = r_sod;
                    n_res.clamped        = r_clamped;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tz        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tz <= i_cfg_data;
            end
        end
        r_epoch   <= n_epoch;
        r_days    <= n_days;
        r_sod     <= n_sod;
        r_second  <= n_second;
        r_minute  <= n_minute;
        r_hour    <= n_hour;
        r_weekday <= n_weekday;
        r_year    <= n_year;
        r_month   <= n_month;
        r_mday    <= n_mday;
        r_clamped <= n_clamped;
        r_res     <= n_res;
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.year             = r_res.year;
    assign o_out.month            = r_res.month;
    assign o_out.day_of_month     = r_res.day_of_month;
    assign o_out.weekday          = r_res.weekday;
    assign o_out.hour             = r_res.hour;
    assign o_out.minute           = r_res.minute;
    assign o_out.second           = r_res.second;
    assign o_out.day_count        = r_res.day_count;
    assign o_out.seconds_of_day   = r_res.seconds_of_day;
    assign o_out.clamped          = r_res.clamped;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Calendar splitter bench: every epoch transfer is predicted against the
// zone offset in force, and each result transfer is checked field by field
// against the oldest pending date.
module testbench;

    // Own constants for the prediction; the span is 1970..2039 inclusive.
    localparam int unsigned DAY_SECS   = 86400;
    localparam int unsigned EPOCH_YEAR = 1970;
    localparam int unsigned LAST_YEAR  = 2039;
    localparam longint      LAST_LOCAL = 64'd2208988799;   // 2039-12-31 23:59:59
    localparam int unsigned MONTH_START [12] = '{0, 31, 59, 90, 120, 151,
                                                 181, 212, 243, 273, 304, 334};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic signed [10:0]  cfg_data;

    esc_in_if  in_if ();
    esc_out_if out_if ();

    epoch_seconds_to_calendar u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Generous cap: several times the slowest legal run (the slowest item
    // plus the longest sender gap and the longest receiver hold).
    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Bench-side copy of the zone register and the dates still owed.
    logic signed [10:0]   zone_minutes_west;
    esc_pkg::t_result     pending_dates [$];
    int unsigned          epochs_sent;
    int unsigned          dates_checked;
    int unsigned          mismatches;
    int unsigned          zones_written;
    int unsigned          stall_pct;
    int unsigned          stall_hold;

    // Gregorian rule in full, even though the span only needs the /4 test.
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_offset(input bit leap, input int unsigned m0);
        return MONTH_START[m0] + ((leap && m0 >= 2) ? 1 : 0);
    endfunction

    // Local seconds of a civil date and time, for aiming stimulus at edges.
    function automatic longint civil_to_secs(input int unsigned y, input int unsigned mon,
                                             input int unsigned d, input int unsigned sod);
        longint      days;
        int unsigned yy;
        days = 0;
        for (yy = EPOCH_YEAR; yy < y; yy++) begin
            days += leap_year(yy) ? 366 : 365;
        end
        days += month_offset(leap_year(y), mon - 1) + d - 1;
        return days * DAY_SECS + sod;
    endfunction

    function automatic esc_pkg::t_result predict_calendar(input logic [31:0] epoch,
                                                          input logic signed [10:0] tz);
        esc_pkg::t_result r;
        longint           local_s;
        int unsigned      t, sod, days, yr, ystart, ylen, yday, m0;
        bit               lp;
        r = '0;
        // Zone is minutes west, so west of UTC moves local time back.
        local_s = longint'(epoch) - 60 * longint'(tz);
        if (local_s < 0) begin
            local_s   = 0;
            r.clamped = 1'b1;
        end else if (local_s > LAST_LOCAL) begin
            local_s   = LAST_LOCAL;
            r.clamped = 1'b1;
        end
        t    = 32'(local_s);
        sod  = t % DAY_SECS;
        days = t / DAY_SECS;
        yr     = EPOCH_YEAR;
        ystart = 0;
        forever begin
            ylen = leap_year(yr) ? 366 : 365;
            if (yr >= LAST_YEAR || days < ystart + ylen) break;
            ystart += ylen;
            yr++;
        end
        yday = days - ystart;
        lp   = leap_year(yr);
        m0   = 11;
        while (m0 > 0 && month_offset(lp, m0) > yday) m0--;
        r.year             = 11'(yr);
        r.month            = 4'(m0 + 1);
        r.day_of_month     = 5'(yday - month_offset(lp, m0) + 1);
        r.weekday          = 3'((days + 3) % 7 + 1);   // day 0 was a Thursday
        r.hour             = 5'(sod / 3600);
        r.minute           = 6'((sod / 60) % 60);
        r.second           = 6'(sod % 60);
        r.day_count        = 15'(days);
        r.seconds_of_day   = 17'(sod);
        return r;
    endfunction

    // One epoch transfer: valid is left high so back-to-back items need no
    // drop; whoever idles next lowers it.
    task automatic send_epoch(input logic [31:0] epoch);
        in_if.valid         <= 1'b1;
        in_if.epoch_seconds <= epoch;
        do @(posedge clk); while (!in_if.ready);
        pending_dates.push_back(predict_calendar(epoch, zone_minutes_west));
        epochs_sent++;
    endtask

    // Sender holds off until every pending date is back.
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only ever called with the block idle.
    task automatic set_zone(input logic signed [10:0] tz);
        cfg_data <= tz;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        zone_minutes_west = tz;
        zones_written++;
    endtask

    task automatic test_calendar_edges();
        set_zone(11'sd0);
        send_epoch(32'd0);
        send_epoch(32'd59);
        send_epoch(32'd3599);
        send_epoch(32'd86399);
        send_epoch(32'd86400);
        send_epoch(32'hFFFF_FFFF);              // far past the top: clamped high
        send_epoch(32'(LAST_LOCAL));            // last second in the span
        send_epoch(32'(LAST_LOCAL + 1));        // first second beyond it
        send_epoch(32'h8000_0000);
        send_epoch(32'h5555_5555);
        send_epoch(32'(civil_to_secs(1972, 2, 29, 0)));        // first leap day
        send_epoch(32'(civil_to_secs(1972, 12, 31, 86399)));   // day 366
        send_epoch(32'(civil_to_secs(2000, 2, 29, 43200)));    // century leap year
        send_epoch(32'(civil_to_secs(2000, 3, 1, 0)));
        send_epoch(32'(civil_to_secs(1999, 12, 31, 86399)));
        send_epoch(32'(civil_to_secs(2039, 12, 31, 0)));
        wait_for_drain();
    endtask

    // Offsets at both legal limits and at the raw 11-bit limits, each aimed
    // so that local time lands just inside and just outside the span.
    task automatic test_zone_edges();
        set_zone(11'sd840);
        send_epoch(32'd50399);
        send_epoch(32'd50400);
        wait_for_drain();
        set_zone(-11'sd840);
        send_epoch(32'(LAST_LOCAL - 50400));
        send_epoch(32'(LAST_LOCAL - 50399));
        send_epoch(32'd0);
        wait_for_drain();
        set_zone(-11'sd1023 - 11'sd1);          // most negative code
        send_epoch(32'(LAST_LOCAL - 61440));
        send_epoch(32'(LAST_LOCAL - 61439));
        wait_for_drain();
        set_zone(11'sd1023);
        send_epoch(32'd61379);
        send_epoch(32'd61380);
        wait_for_drain();
    endtask

    // Random times under one flow-control mix; the zone changes between
    // chunks, each change after a full drain.
    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall);
        logic signed [10:0] tz;
        logic [31:0]        epoch;
        longint             aim;
        int unsigned        c, n, sel, gap, yr, mon;
        stall_pct = stall;
        for (c = 0; c < 4; c++) begin
            wait_for_drain();
            case (c)
                1: begin
                    case ($urandom_range(3, 0))
                        0:       tz = -11'sd840;
                        1:       tz = 11'sd840;
                        2:       tz = -11'sd1023 - 11'sd1;
                        default: tz = 11'sd1023;
                    endcase
                end
                2:       tz = 11'($urandom_range(2047, 0));   // any code, out of range too
                default: tz = 11'(int'($urandom_range(1680, 0)) - 840);
            endcase
            set_zone(tz);
            for (n = 0; n < 95; n++) begin
                sel = $urandom_range(99, 0);
                if (sel < 70) begin
                    epoch = $urandom_range(32'd2208988799, 0);
                end else if (sel < 90) begin
                    // Straddle a local month start (or the end of the span),
                    // which also hits year ends and the leap days.
                    yr  = $urandom_range(LAST_YEAR + 1, EPOCH_YEAR);
                    mon = (yr > LAST_YEAR) ? 1 : $urandom_range(12, 1);
                    aim = civil_to_secs(yr, mon, 1, 0) + 60 * longint'(zone_minutes_west)
                          + longint'($urandom_range(4, 0)) - 2;
                    epoch = 32'(aim);
                end else begin
                    epoch = $urandom();
                end
                gap = 0;
                if (idle_pct > 0) begin
                    while ($urandom_range(99, 0) < idle_pct) gap++;
                    // now and then a long gap, so idles land on every stage
                    if ($urandom_range(15, 0) == 0) gap += $urandom_range(220, 1);
                end
                if (gap > 0) begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                send_epoch(epoch);
            end
        end
        wait_for_drain();
    endtask

    // Receiver: per-cycle random ready, plus rare long holds so that a
    // finished result sits while the next item is worked on.
    initial begin
        out_if.ready = 1'b0;
        stall_hold   = 0;
        forever begin
            @(posedge clk);
            if (stall_hold > 0) begin
                out_if.ready <= 1'b0;
                stall_hold--;
            end else if (stall_pct > 0 && $urandom_range(255, 0) == 0) begin
                out_if.ready <= 1'b0;
                stall_hold = $urandom_range(250, 1);
            end else begin
                out_if.ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    esc_pkg::t_result want_date;

    // Result transfers are sampled at the edge, before any update lands.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_dates.size() == 0) begin
                mismatches++;
                $display("%0t: result with no date pending, expected none, actual %0d-%0d-%0d",
                         $time, out_if.year, out_if.month, out_if.day_of_month);
            end else begin
                want_date = pending_dates.pop_front();
                check_field("year", 32'(want_date.year), 32'(out_if.year));
                check_field("month", 32'(want_date.month), 32'(out_if.month));
                check_field("day_of_month", 32'(want_date.day_of_month),
                            32'(out_if.day_of_month));
                check_field("weekday", 32'(want_date.weekday), 32'(out_if.weekday));
                check_field("hour", 32'(want_date.hour), 32'(out_if.hour));
                check_field("minute", 32'(want_date.minute), 32'(out_if.minute));
                check_field("second", 32'(want_date.second), 32'(out_if.second));
                check_field("day_count", 32'(want_date.day_count),
                            32'(out_if.day_count));
                check_field("seconds_of_day", 32'(want_date.seconds_of_day),
                            32'(out_if.seconds_of_day));
                check_field("clamped", 32'(want_date.clamped), 32'(out_if.clamped));
                dates_checked++;
            end
        end
    end

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        in_if.valid         = 1'b0;
        in_if.epoch_seconds = '0;
        zone_minutes_west   = '0;
        stall_pct           = 0;
        epochs_sent         = 0;
        dates_checked       = 0;
        mismatches          = 0;
        zones_written       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_calendar_edges();
        test_zone_edges();
        test_random_phase(0, 0);
        test_random_phase(84, 0);
        test_random_phase(0, 84);
        test_random_phase(20, 20);

        // Catch any stray result after the last one owed.
        wait_for_drain();
        repeat (300) @(posedge clk);

        $display("Run covered %0d epoch transfers and %0d checked dates over %0d zone writes,",
                 epochs_sent, dates_checked, zones_written);
        $display("with span and zone edges, leap days, clamping both ways and four idle mixes.");
        if (mismatches == 0 && pending_dates.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/esc_pkg.sv
rtl/core/esc_in_if.sv
rtl/core/esc_out_if.sv
rtl/core/esc_serdiv.sv
rtl/core/esc_datewalk.sv
rtl/core/epoch_seconds_to_calendar.sv
sim/testbench.sv
